>>> sv/rsrd_pkg.sv
// Shared types and constants for the RGBE scanline run-length decoder.
// No dependencies; imported by the core, output stage and top level.
`default_nettype none
package rsrd_pkg;

  localparam int unsigned WIDTH_BITS = 15;

  localparam logic [WIDTH_BITS-1:0] MAX_WIDTH     = 15'd32767;
  localparam logic [WIDTH_BITS-1:0] MIN_NEW_WIDTH = 15'd8;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET   = 15'd8;

  localparam logic [7:0]  HDR_MARK  = 8'd2;
  localparam logic [7:0]  REP_BASE  = 8'd128;
  localparam logic [23:0] RUN_MARK  = 24'h010101;
  localparam logic [1:0]  SHIFT_MAX = 2'd3;
  localparam logic [1:0]  LAST_PLANE = 2'd3;
  localparam logic [1:0]  LAST_SLOT  = 2'd3;

  localparam logic [2:0] CH_PIXEL = 3'd4;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] position;
    logic [2:0]            channel;
    logic [31:0]           value;
    logic [WIDTH_BITS-1:0] count;
    logic                  line_end;
    logic                  overrun;
  } cmd_t;

endpackage
`default_nettype wire

>>> sv/rsrd_byte_if.sv
// Byte stream channel: valid/ready handshake carrying one encoded byte.
// No dependencies.
`default_nettype none
interface rsrd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface
`default_nettype wire

>>> sv/rsrd_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying the line width.
// No dependencies.
`default_nettype none
interface rsrd_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] line_width;

  modport source (output valid, output line_width, input ready);
  modport sink   (input valid, input line_width, output ready);
endinterface
`default_nettype wire

>>> sv/rsrd_cmd_if.sv
// Write command channel: valid/ready handshake carrying one frame-store write.
// No dependencies.
`default_nettype none
interface rsrd_cmd_if;
  logic        valid;
  logic        ready;
  logic [14:0] position;
  logic [2:0]  channel;
  logic [31:0] value;
  logic [14:0] count;
  logic        line_end;
  logic        overrun;

  modport source (output valid, output position, output channel, output value,
                  output count, output line_end, output overrun, input ready);
  modport sink   (input valid, input position, input channel, input value,
                  input count, input line_end, input overrun, output ready);
endinterface
`default_nettype wire

>>> sv/rsrd_core.sv
// Decode state machine: line width register, scanline state and the
// per-byte next-state and write command logic. Depends on rsrd_pkg.
`default_nettype none
module rsrd_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_fire,
  input  logic [7:0]                     byte_in,
  input  logic                           cfg_fire,
  input  logic [rsrd_pkg::WIDTH_BITS-1:0] cfg_width,
  output logic                           res_valid,
  output rsrd_pkg::cmd_t                 res
);
  import rsrd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_OLD, PH_CODE, PH_REPVAL, PH_LIT
  } phase_t;

  logic [WIDTH_BITS-1:0] line_width;

  phase_t                phase, phase_next;
  logic [1:0]            slot, slot_next;
  logic [23:0]           asm_pix, asm_pix_next;
  logic [WIDTH_BITS-1:0] pix, pix_next;
  logic [1:0]            plane, plane_next;
  logic [7:0]            lit, lit_next;
  logic [1:0]            shift, shift_next;
  logic [31:0]           prev, prev_next;

  logic [WIDTH_BITS-1:0] w_eff;
  logic [WIDTH_BITS-1:0] rem;
  logic [WIDTH_BITS-1:0] cnt;
  logic [31:0]           run_n;
  logic [31:0]           put_n;
  logic [31:0]           put_val;
  logic [2:0]            put_ch;
  logic                  do_put;
  logic                  over;
  logic                  old_path;
  logic                  old_chk;
  logic                  new_chk;
  logic                  end_line;

  assign w_eff = (line_width == '0) ? WIDTH_BITS'(1) : line_width;

  always_comb begin
    unique case (shift)
      2'd0: run_n = {24'h0, byte_in};
      2'd1: run_n = {16'h0, byte_in, 8'h0};
      2'd2: run_n = {8'h0, byte_in, 16'h0};
      2'd3: run_n = {byte_in, 24'h0};
    endcase
  end

  always_comb begin
    phase_next   = phase;
    slot_next    = slot;
    asm_pix_next = asm_pix;
    pix_next     = pix;
    plane_next   = plane;
    lit_next     = lit;
    shift_next   = shift;
    prev_next    = prev;
    do_put       = 1'b0;
    put_ch       = CH_PIXEL;
    put_val      = '0;
    put_n        = '0;
    old_path     = 1'b0;
    old_chk      = 1'b0;
    new_chk      = 1'b0;
    end_line     = 1'b0;

    unique case (phase)
      PH_HDR0: begin
        if (w_eff < MIN_NEW_WIDTH || w_eff > MAX_WIDTH || byte_in != HDR_MARK) begin
          phase_next = PH_OLD;
          old_path   = 1'b1;
        end else begin
          phase_next = PH_HDR1;
        end
      end
      PH_HDR1: begin
        asm_pix_next = {16'h0, byte_in};
        phase_next   = PH_HDR2;
      end
      PH_HDR2: begin
        asm_pix_next = {8'h0, asm_pix[7:0], byte_in};
        phase_next   = PH_HDR3;
      end
      PH_HDR3: begin
        asm_pix_next = '0;
        if (asm_pix[15:8] != HDR_MARK || asm_pix[7]) begin
          prev_next  = {HDR_MARK, asm_pix[15:0], byte_in};
          slot_next  = '0;
          shift_next = '0;
          phase_next = PH_OLD;
          do_put     = 1'b1;
          put_val    = {HDR_MARK, asm_pix[15:0], byte_in};
          put_n      = 32'd1;
          old_chk    = 1'b1;
        end else begin
          plane_next = '0;
          pix_next   = '0;
          phase_next = PH_CODE;
        end
      end
      PH_OLD: old_path = 1'b1;
      PH_CODE: begin
        if (byte_in > REP_BASE) begin
          lit_next   = {1'b0, byte_in[6:0]};
          phase_next = PH_REPVAL;
        end else if (byte_in != 8'h0) begin
          lit_next   = byte_in;
          phase_next = PH_LIT;
        end
      end
      PH_REPVAL: begin
        lit_next   = '0;
        phase_next = PH_CODE;
        do_put     = 1'b1;
        put_ch     = {1'b0, plane};
        put_val    = {24'h0, byte_in};
        put_n      = {24'h0, lit};
        new_chk    = 1'b1;
      end
      PH_LIT: begin
        lit_next = (lit != 8'h0) ? lit - 8'd1 : lit;
        if (lit_next == 8'h0) begin
          phase_next = PH_CODE;
        end
        do_put  = 1'b1;
        put_ch  = {1'b0, plane};
        put_val = {24'h0, byte_in};
        put_n   = 32'd1;
        new_chk = 1'b1;
      end
    endcase

    if (old_path) begin
      if (slot != LAST_SLOT) begin
        asm_pix_next = {asm_pix[15:0], byte_in};
        slot_next    = slot + 2'd1;
      end else begin
        slot_next = '0;
        old_chk   = 1'b1;
        if (asm_pix == RUN_MARK) begin
          shift_next = (shift == SHIFT_MAX) ? SHIFT_MAX : shift + 2'd1;
          put_n      = run_n;
          put_val    = prev;
          do_put     = (run_n != '0);
        end else begin
          prev_next  = {asm_pix, byte_in};
          shift_next = '0;
          put_val    = {asm_pix, byte_in};
          put_n      = 32'd1;
          do_put     = 1'b1;
        end
      end
    end

    rem  = (pix < w_eff) ? w_eff - pix : '0;
    over = (put_n[31:WIDTH_BITS] != '0) || (put_n[WIDTH_BITS-1:0] > rem);
    cnt  = over ? rem : put_n[WIDTH_BITS-1:0];

    if (do_put) begin
      pix_next = pix + cnt;
    end

    if (do_put && old_chk && pix_next >= w_eff) begin
      end_line = 1'b1;
    end
    if (do_put && new_chk && lit_next == 8'h0 && pix_next >= w_eff) begin
      if (plane >= LAST_PLANE) begin
        end_line = 1'b1;
      end else begin
        plane_next = plane + 2'd1;
        pix_next   = '0;
        phase_next = PH_CODE;
      end
    end

    if (end_line) begin
      phase_next   = PH_HDR0;
      slot_next    = '0;
      asm_pix_next = '0;
      pix_next     = '0;
      plane_next   = '0;
      lit_next     = '0;
      shift_next   = '0;
    end
  end

  always_comb begin
    res_valid    = do_put;
    res.position = pix;
    res.channel  = put_ch;
    res.value    = put_val;
    res.count    = cnt;
    res.line_end = end_line;
    res.overrun  = over;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= WIDTH_RESET;
    end else if (cfg_fire) begin
      line_width <= cfg_width;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HDR0;
      slot    <= '0;
      asm_pix <= '0;
      pix     <= '0;
      plane   <= '0;
      lit     <= '0;
      shift   <= '0;
      prev    <= '0;
    end else if (in_fire) begin
      phase   <= phase_next;
      slot    <= slot_next;
      asm_pix <= asm_pix_next;
      pix     <= pix_next;
      plane   <= plane_next;
      lit     <= lit_next;
      shift   <= shift_next;
      prev    <= prev_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/rsrd_out_reg.sv
// Result register between the decode logic and the write command channel.
// Depends on rsrd_pkg.
`default_nettype none
module rsrd_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           res_valid,
  input  rsrd_pkg::cmd_t res,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output rsrd_pkg::cmd_t out_cmd
);
  import rsrd_pkg::*;

  logic open_slot;

  assign open_slot = !out_valid || out_ready;
  assign in_ready  = open_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (open_slot) begin
      out_valid <= in_fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (open_slot && in_fire && res_valid) begin
      out_cmd <= res;
    end
  end

endmodule
`default_nettype wire

>>> sv/rgbe_scanline_rle_decoder_top.sv
// RGBE scanline run-length decoder top level: one encoded byte per request,
// at most one frame-store write command out. A write appears in the cycle
// after the byte that causes it is accepted. Throughput: one byte per
// cycle while the write command channel keeps up; a single result register
// holds a write the sink has not taken. Reset clears line state, the previous
// pixel and the result register's valid flag, and sets the line width to 8.
// Depends on rsrd_pkg, rsrd_byte_if, rsrd_cfg_if, rsrd_cmd_if, rsrd_core,
// rsrd_out_reg.
`default_nettype none
module rgbe_scanline_rle_decoder_top (
  input  logic       clk,
  input  logic       rst,
  rsrd_byte_if.sink  byte_stream,
  rsrd_cfg_if.sink   cfg,
  rsrd_cmd_if.source write_cmd
);
  import rsrd_pkg::*;

  logic in_ready;
  logic in_fire;
  logic cfg_fire;
  logic res_valid;
  cmd_t res;
  cmd_t out_cmd;

  assign byte_stream.ready = in_ready;
  assign in_fire           = byte_stream.valid && in_ready;
  assign cfg.ready         = 1'b1;
  assign cfg_fire          = cfg.valid;

  rsrd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .byte_in   (byte_stream.byte_in),
    .cfg_fire  (cfg_fire),
    .cfg_width (cfg.line_width),
    .res_valid (res_valid),
    .res       (res)
  );

  rsrd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .res_valid (res_valid),
    .res       (res),
    .in_ready  (in_ready),
    .out_valid (write_cmd.valid),
    .out_ready (write_cmd.ready),
    .out_cmd   (out_cmd)
  );

  assign write_cmd.position = out_cmd.position;
  assign write_cmd.channel  = out_cmd.channel;
  assign write_cmd.value    = out_cmd.value;
  assign write_cmd.count    = out_cmd.count;
  assign write_cmd.line_end = out_cmd.line_end;
  assign write_cmd.overrun  = out_cmd.overrun;

endmodule
`default_nettype wire
